// File: sv/hfd_pkg.sv
// Shared types, constants and the arctangent table for the heading core.
// Used by every module of the heading_from_displacement_core block.
`timescale 1ns / 1ps

package hfd_pkg;

    // Default configuration.
    localparam int COORD_WIDTH_DEF   = 24;
    localparam int CORDIC_STAGES_DEF = 20;

    // Rotation datapath: displacement is scaled so its top sits near bit 60.
    localparam int SCALE_TOP = 60;
    localparam int XW        = 64;

    // Angle accumulator, signed, 1/65536 degree.
    localparam int ZW     = 26;
    localparam int FOLD_W = ZW - 1;
    localparam logic signed [ZW-1:0] QUARTER_Z   = ZW'(5898240);
    localparam logic signed [ZW-1:0] FULL_TURN_Z = ZW'(23592960);

    // Output heading, 1/256 degree.
    localparam int HEAD_W   = 17;
    localparam int DROP_W   = 8;
    localparam logic [FOLD_W-1:0] ROUND_HALF     = FOLD_W'(128);
    localparam logic [HEAD_W-1:0] FULL_TURN_HEAD = HEAD_W'(92160);

    localparam int ATAN_IDX_W = 5;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } rot_t;

    // atan(2^-i) in degrees times 65536, rounded to nearest.
    function automatic logic signed [ZW-1:0] atan_deg(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [ZW-1:0] val;
        begin
            case (idx)
                5'd0:    val = ZW'(2949120);
                5'd1:    val = ZW'(1740967);
                5'd2:    val = ZW'(919879);
                5'd3:    val = ZW'(466945);
                5'd4:    val = ZW'(234379);
                5'd5:    val = ZW'(117304);
                5'd6:    val = ZW'(58666);
                5'd7:    val = ZW'(29335);
                5'd8:    val = ZW'(14668);
                5'd9:    val = ZW'(7334);
                5'd10:   val = ZW'(3667);
                5'd11:   val = ZW'(1833);
                5'd12:   val = ZW'(917);
                5'd13:   val = ZW'(458);
                5'd14:   val = ZW'(229);
                5'd15:   val = ZW'(115);
                5'd16:   val = ZW'(57);
                5'd17:   val = ZW'(29);
                5'd18:   val = ZW'(14);
                5'd19:   val = ZW'(7);
                5'd20:   val = ZW'(4);
                5'd21:   val = ZW'(2);
                5'd22:   val = ZW'(1);
                default: val = '0;
            endcase
            return val;
        end
    endfunction

endpackage

// File: sv/heading_from_displacement_core.sv
// Top level of the heading core: front end, CORDIC stage chain and back end.
// Depends on hfd_pkg, hfd_prep, hfd_cordic_stage and hfd_post.
`timescale 1ns / 1ps

// Usage
// A position beat (cur_x, cur_y, prev_x, prev_y, signed with 8 fraction bits)
// is taken when pos_valid is high and pos_stall is low. The core forms the
// displacement, finds its direction with a vectoring CORDIC and returns one
// heading beat in 1/256 degree, counterclockwise from +x, in the range 0 to
// 92159. A zero displacement gives a heading of zero.
// The heading beat passes through two front-end stages, one register per
// CORDIC iteration, a wrap stage and the output register. One beat is taken
// in every cycle while pos_stall is low; each CORDIC iteration has its own
// adder stage, so nothing is shared between beats.
// When heading_stall is high, beats stay where they are while empty stages
// ahead of them fill; pos_stall rises only once every stage holds a beat and
// the output is stalled. No beat is lost or repeated.
// Reset (rst_n low, asynchronous) empties every stage, so pos_stall is low
// once reset is released.
module heading_from_displacement_core
    import hfd_pkg::*;
#(
    parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pos_valid,
    output logic                          pos_stall,
    input  logic signed [COORD_WIDTH-1:0] cur_x,
    input  logic signed [COORD_WIDTH-1:0] cur_y,
    input  logic signed [COORD_WIDTH-1:0] prev_x,
    input  logic signed [COORD_WIDTH-1:0] prev_y,
    output logic                          heading_valid,
    input  logic                          heading_stall,
    output logic [HEAD_W-1:0]             heading
);

    // Element k feeds CORDIC iteration k; element CORDIC_STAGES feeds the back end.
    rot_t stage_data  [0:CORDIC_STAGES];
    logic stage_valid [0:CORDIC_STAGES];
    logic stage_rdy   [0:CORDIC_STAGES];
    logic prep_rdy;
    logic all_full;

    hfd_prep #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (pos_valid),
        .cur_x    (cur_x),
        .cur_y    (cur_y),
        .prev_x   (prev_x),
        .prev_y   (prev_y),
        .rdy      (prep_rdy),
        .dn_rdy   (stage_rdy[0]),
        .dn_valid (stage_valid[0]),
        .dn_data  (stage_data[0])
    );

    genvar k;
    generate
        for (k = 0; k < CORDIC_STAGES; k++)
        begin : g_iter
            hfd_cordic_stage #(
                .STAGE_IDX (k)
            ) u_stage (
                .clk      (clk),
                .rst_n    (rst_n),
                .up_valid (stage_valid[k]),
                .up_data  (stage_data[k]),
                .rdy      (stage_rdy[k]),
                .dn_rdy   (stage_rdy[k+1]),
                .dn_valid (stage_valid[k+1]),
                .dn_data  (stage_data[k+1])
            );
        end
    endgenerate

    hfd_post u_post (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (stage_valid[CORDIC_STAGES]),
        .up_data  (stage_data[CORDIC_STAGES]),
        .rdy      (stage_rdy[CORDIC_STAGES]),
        .dn_stall (heading_stall),
        .dn_valid (heading_valid),
        .heading  (heading)
    );

    assign pos_stall = !prep_rdy;

    // Occupancy of the CORDIC chain, used only by the checks below.
    always_comb
    begin
        all_full = 1'b1;
        for (int i = 0; i <= CORDIC_STAGES; i++)
        begin
            all_full = all_full && stage_valid[i];
        end
    end

    // The input may only stall when the chain is full and the output is held.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        pos_stall |-> (all_full && heading_valid && heading_stall))
        else $error("input stalled while the pipeline had room");

    // A beat waiting in front of a stalled first iteration stays where it is.
    a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid[0] && !stage_rdy[0]) |=> stage_valid[0])
        else $error("front end lost a waiting beat");

    // Rounding and wrap keep the heading below a full turn.
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        heading_valid |-> (heading < FULL_TURN_HEAD))
        else $error("heading outside one turn");

endmodule

// File: sv/hfd_prep.sv
// Front end of the heading core: displacement, then quadrant fold and scaling.
// Two register stages; depends on hfd_pkg.
`timescale 1ns / 1ps

module hfd_prep
    import hfd_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          up_valid,
    input  logic signed [COORD_WIDTH-1:0] cur_x,
    input  logic signed [COORD_WIDTH-1:0] cur_y,
    input  logic signed [COORD_WIDTH-1:0] prev_x,
    input  logic signed [COORD_WIDTH-1:0] prev_y,
    output logic                          rdy,
    input  logic                          dn_rdy,
    output logic                          dn_valid,
    output rot_t                          dn_data
);

    localparam int DW       = COORD_WIDTH + 1;
    localparam int PRESHIFT = SCALE_TOP - COORD_WIDTH;

    logic                 diff_valid_reg;
    logic signed [DW-1:0] dx_reg;
    logic signed [DW-1:0] dy_reg;
    logic signed [DW-1:0] dx_next;
    logic signed [DW-1:0] dy_next;
    logic                 rot_valid_reg;
    rot_t                 rot_reg;
    rot_t                 rot_next;
    logic                 rdy_b;
    logic signed [DW-1:0] px;
    logic signed [DW-1:0] py;

    // A stage takes a new beat when it is empty or its successor moves.
    assign rdy_b = !rot_valid_reg || dn_rdy;
    assign rdy   = !diff_valid_reg || rdy_b;

    assign dx_next = {cur_x[COORD_WIDTH-1], cur_x} - {prev_x[COORD_WIDTH-1], prev_x};
    assign dy_next = {cur_y[COORD_WIDTH-1], cur_y} - {prev_y[COORD_WIDTH-1], prev_y};

    // Turn a vector in the left half plane by a quarter so that x is not negative.
    always_comb
    begin
        px         = dx_reg;
        py         = dy_reg;
        rot_next.z = '0;
        if (dx_reg[DW-1])
        begin
            if (!dy_reg[DW-1])
            begin
                px         = dy_reg;
                py         = -dx_reg;
                rot_next.z = QUARTER_Z;
            end
            else
            begin
                px         = -dy_reg;
                py         = dx_reg;
                rot_next.z = -QUARTER_Z;
            end
        end
        rot_next.x    = {{(XW-DW){px[DW-1]}}, px} <<< PRESHIFT;
        rot_next.y    = {{(XW-DW){py[DW-1]}}, py} <<< PRESHIFT;
        rot_next.zero = (dx_reg == '0) && (dy_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_valid_reg <= 1'b0;
            rot_valid_reg  <= 1'b0;
        end
        else
        begin
            if (rdy)
            begin
                diff_valid_reg <= up_valid;
            end
            if (rdy_b)
            begin
                rot_valid_reg <= diff_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy && up_valid)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (rdy_b && diff_valid_reg)
        begin
            rot_reg <= rot_next;
        end
    end

    assign dn_valid = rot_valid_reg;
    assign dn_data  = rot_reg;

endmodule

// File: sv/hfd_cordic_stage.sv
// One vectoring CORDIC iteration with its own register stage.
// Depends on hfd_pkg for the rotation type and the arctangent table.
`timescale 1ns / 1ps

module hfd_cordic_stage
    import hfd_pkg::*;
#(
    parameter int STAGE_IDX = 0
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic up_valid,
    input  rot_t up_data,
    output logic rdy,
    input  logic dn_rdy,
    output logic dn_valid,
    output rot_t dn_data
);

    localparam logic signed [ZW-1:0] STEP_ANGLE = atan_deg(ATAN_IDX_W'(STAGE_IDX));

    logic                 valid_reg;
    rot_t                 data_reg;
    rot_t                 data_next;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;

    assign rdy = !valid_reg || dn_rdy;

    assign xs = up_data.x >>> STAGE_IDX;
    assign ys = up_data.y >>> STAGE_IDX;

    // Rotate toward the x axis: clockwise while y is not negative.
    always_comb
    begin
        data_next.zero = up_data.zero;
        if (!up_data.y[XW-1])
        begin
            data_next.x = up_data.x + ys;
            data_next.y = up_data.y - xs;
            data_next.z = up_data.z + STEP_ANGLE;
        end
        else
        begin
            data_next.x = up_data.x - ys;
            data_next.y = up_data.y + xs;
            data_next.z = up_data.z - STEP_ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (rdy)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// File: sv/hfd_post.sv
// Back end of the heading core: wrap to a full turn, then round to 1/256 degree.
// Two register stages, the second is the output register; depends on hfd_pkg.
`timescale 1ns / 1ps

module hfd_post
    import hfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    input  rot_t              up_data,
    output logic              rdy,
    input  logic              dn_stall,
    output logic              dn_valid,
    output logic [HEAD_W-1:0] heading
);

    logic                     fold_valid_reg;
    logic [FOLD_W-1:0]        fold_reg;
    logic [FOLD_W-1:0]        fold_next;
    logic signed [ZW-1:0]     z_wrap;
    logic                     out_valid_reg;
    logic [HEAD_W-1:0]        head_reg;
    logic [HEAD_W-1:0]        head_next;
    logic [FOLD_W-1:0]        rounded;
    logic [HEAD_W-1:0]        head_raw;
    logic                     rdy_b;

    assign rdy_b = !out_valid_reg || !dn_stall;
    assign rdy   = !fold_valid_reg || rdy_b;

    // Negative angles move up by a full turn; a zero displacement reads as zero.
    always_comb
    begin
        z_wrap = up_data.z;
        if (up_data.z[ZW-1])
        begin
            z_wrap = up_data.z + FULL_TURN_Z;
        end
        if (up_data.zero || z_wrap[ZW-1])
        begin
            fold_next = '0;
        end
        else
        begin
            fold_next = z_wrap[FOLD_W-1:0];
        end
    end

    assign rounded  = fold_reg + ROUND_HALF;
    assign head_raw = rounded[FOLD_W-1:DROP_W];

    always_comb
    begin
        if (head_raw >= FULL_TURN_HEAD)
        begin
            head_next = head_raw - FULL_TURN_HEAD;
        end
        else
        begin
            head_next = head_raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (rdy)
            begin
                fold_valid_reg <= up_valid;
            end
            if (rdy_b)
            begin
                out_valid_reg <= fold_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy && up_valid)
        begin
            fold_reg <= fold_next;
        end
        if (rdy_b && fold_valid_reg)
        begin
            head_reg <= head_next;
        end
    end

    assign dn_valid = out_valid_reg;
    assign heading  = head_reg;

endmodule
